FILE: sv/sla_pkg.sv
`default_nettype none

package sla_pkg;

  localparam int BLOCK_WIDTH_DEF  = 128;
  localparam int BLOCK_HEIGHT_DEF = 128;
  localparam int MAX_PAGES_DEF    = 256;

  localparam int REQ_W  = 8;
  localparam int PAGE_W = 8;
  localparam int POS_W  = 7;

  // Data-stage controls for the window maximum unit.
  typedef struct packed {
    logic clr;        // start of a request: reset the best-window search
    logic fwd;        // forward sweep: build block prefix maxima
    logic bwd;        // backward sweep: block suffix maxima and window search
    logic blk_start;  // column opens a block (forward sweep)
    logic blk_end;    // column closes a block (backward sweep)
    logic cand;       // column is a legal start for the window
  } wmax_ctl_t;

endpackage

`default_nettype wire

FILE: sv/sla_wmax.sv
`default_nettype none

// Sliding-window maximum over the skyline in two sweeps (block prefix and
// suffix maxima), with a search for the first window of least maximum.
module sla_wmax #(
  parameter int BLOCK_WIDTH  = sla_pkg::BLOCK_WIDTH_DEF,
  parameter int BLOCK_HEIGHT = sla_pkg::BLOCK_HEIGHT_DEF,
  localparam int AW = $clog2(BLOCK_WIDTH),
  localparam int HW = $clog2(BLOCK_HEIGHT + 1)
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire  sla_pkg::wmax_ctl_t ctl_i,
  input  wire  logic [HW-1:0]     sky_i,
  input  wire  logic [AW-1:0]     pos_i,
  input  wire  logic [AW-1:0]     g_raddr_i,
  output logic [HW-1:0]           best_o,
  output logic [AW-1:0]           bx_o,
  output logic                    found_o
);

  localparam logic [HW-1:0] BhH = HW'(BLOCK_HEIGHT);

  logic [HW-1:0] g_mem [BLOCK_WIDTH];
  logic [HW-1:0] g_rd_q;
  logic [HW-1:0] run_q, run_d;
  logic [HW-1:0] best_q, best_d;
  logic [AW-1:0] bx_q, bx_d;
  logic          found_q, found_d;
  logic          restart;
  logic [HW-1:0] win_max;

  always_comb begin
    restart = ctl_i.fwd ? ctl_i.blk_start : ctl_i.blk_end;
    run_d   = (restart || sky_i > run_q) ? sky_i : run_q;
    win_max = (g_rd_q > run_d) ? g_rd_q : run_d;
    best_d  = best_q;
    bx_d    = bx_q;
    found_d = found_q;
    if (ctl_i.clr) begin
      best_d  = BhH;
      found_d = 1'b0;
    end else if (ctl_i.bwd && ctl_i.cand && win_max <= best_q && win_max < BhH) begin
      // descending sweep: ties move the pick toward the lower start
      best_d  = win_max;
      bx_d    = pos_i;
      found_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.fwd) begin
      g_mem[pos_i] <= run_d;
    end
    g_rd_q <= g_mem[g_raddr_i];
    if (ctl_i.fwd || ctl_i.bwd) begin
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q  <= BhH;
      bx_q    <= '0;
      found_q <= 1'b0;
    end else begin
      best_q  <= best_d;
      bx_q    <= bx_d;
      found_q <= found_d;
    end
  end

  assign best_o  = best_q;
  assign bx_o    = bx_q;
  assign found_o = found_q;

`ifndef ASSERT_OFF
  ap_found_below_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> best_q < BhH)
    else $error("found window reaches page top");

  ap_found_clears_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(found_q) |-> $past(ctl_i.clr))
    else $error("window search lost its pick mid-request");

  ap_best_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q && !ctl_i.clr |=> best_q <= $past(best_q))
    else $error("best window maximum grew during search");
`endif

endmodule

`default_nettype wire

FILE: sv/skyline_lightmap_allocator.sv
// Channel   Direction  Handshake                Payload
// request   in         in_valid_i / in_stall_o  req_width_i, req_height_i
// result    out        out_valid_o / out_stall_i page_o, pos_x_o, pos_y_o, ok_o,
//                                               opened_page_o
//
// Sequencing: one request at a time. Placement on the open page runs a forward
//   sweep, a backward sweep, a wait to settle the pick, and one skyline write per
//   raised column. Opening a page after a failed scan adds a write of every
//   column; the first request only writes every column, and a rejected request
//   goes straight to the response.
// The pace is set by the single read port and single write port of the
//   skyline memory: every sweep and every column update is one access a cycle.
// Reset: no page is open, so no skyline entry is read before the first
//   request rewrites the whole memory; the memory itself is not cleared.
// Stalls: a new request is taken while an earlier result waits; the result
//   register holds until out_stall_i drops.
`default_nettype none

module skyline_lightmap_allocator #(
  parameter int BLOCK_WIDTH  = sla_pkg::BLOCK_WIDTH_DEF,
  parameter int BLOCK_HEIGHT = sla_pkg::BLOCK_HEIGHT_DEF,
  parameter int MAX_PAGES    = sla_pkg::MAX_PAGES_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  wire  logic [sla_pkg::REQ_W-1:0]   req_width_i,
  input  wire  logic [sla_pkg::REQ_W-1:0]   req_height_i,
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output logic [sla_pkg::PAGE_W-1:0]        page_o,
  output logic [sla_pkg::POS_W-1:0]         pos_x_o,
  output logic [sla_pkg::POS_W-1:0]         pos_y_o,
  output logic                              ok_o,
  output logic                              opened_page_o
);

  localparam int ReqW  = sla_pkg::REQ_W;
  localparam int PageW = sla_pkg::PAGE_W;
  localparam int PosW  = sla_pkg::POS_W;
  localparam int AW    = $clog2(BLOCK_WIDTH);
  localparam int HW    = $clog2(BLOCK_HEIGHT + 1);
  localparam int PW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  // wide enough for a column plus a request width, and for BLOCK_WIDTH
  localparam int SW    = ((AW > ReqW) ? AW : ReqW) + 1;
  localparam logic [AW-1:0] LastCol = AW'(BLOCK_WIDTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FWD,
    ST_BWD,
    ST_EVAL,
    ST_RAISE,
    ST_CLEAR,
    ST_RESP
  } state_e;

  state_e            state_q, state_d;
  logic [ReqW-1:0]   w_q, w_d;
  logic [HW-1:0]     h_q, h_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic [ReqW-1:0]   rcnt_q, rcnt_d;
  logic [ReqW-1:0]   ph_q, ph_d;
  logic [HW-1:0]     top_q, top_d;
  logic              d_vld_q, d_vld_d;
  logic              d_fwd_q, d_fwd_d;
  logic [AW-1:0]     d_addr_q, d_addr_d;
  logic [PW-1:0]     cur_q, cur_d;
  logic              open_q, open_d;

  // pending result, held until the output register is free
  logic [PageW-1:0]  rp_q, rp_d;
  logic [PosW-1:0]   rx_q, rx_d;
  logic [PosW-1:0]   ry_q, ry_d;
  logic              rok_q, rok_d;
  logic              ropen_q, ropen_d;

  logic              out_valid_q, out_valid_d;
  logic [PageW-1:0]  page_q, page_d;
  logic [PosW-1:0]   pos_x_q, pos_x_d;
  logic [PosW-1:0]   pos_y_q, pos_y_d;
  logic              ok_q, ok_d;
  logic              opened_q, opened_d;

  logic [HW-1:0]     sky_mem [BLOCK_WIDTH];
  logic [HW-1:0]     sky_rd_q;
  logic              sky_we, sky_re;
  logic [HW-1:0]     sky_wd;

  sla_pkg::wmax_ctl_t ctl;
  logic [AW-1:0]     g_raddr;
  logic [SW-1:0]     g_sum;
  logic [HW-1:0]     best;
  logic [AW-1:0]     bx;
  logic              found;

  logic [ReqW-1:0]   w_m1;
  logic [PW:0]       next_page;
  logic              req_bad;
  logic              fits;

  sla_wmax #(
    .BLOCK_WIDTH  (BLOCK_WIDTH),
    .BLOCK_HEIGHT (BLOCK_HEIGHT)
  ) u_wmax (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .sky_i     (sky_rd_q),
    .pos_i     (d_addr_q),
    .g_raddr_i (g_raddr),
    .best_o    (best),
    .bx_o      (bx),
    .found_o   (found)
  );

  always_comb begin
    w_m1      = w_q - ReqW'(1);
    // prefix maximum at the far end of the window starting at addr_q
    g_sum     = SW'(addr_q) + SW'(w_q) - SW'(1);
    g_raddr   = (g_sum > SW'(BLOCK_WIDTH - 1)) ? LastCol : AW'(g_sum);
    next_page = open_q ? ((PW + 1)'(cur_q) + (PW + 1)'(1)) : '0;
    req_bad   = (req_width_i == '0) || (req_height_i == '0) ||
                (int'(req_width_i) >= BLOCK_WIDTH) || (int'(req_height_i) > BLOCK_HEIGHT);
    fits      = found && (((HW + 1)'(best) + (HW + 1)'(h_q)) <= (HW + 1)'(BLOCK_HEIGHT));

    ctl           = '0;
    ctl.fwd       = d_vld_q && d_fwd_q;
    ctl.bwd       = d_vld_q && !d_fwd_q;
    ctl.blk_start = (ph_q == '0);
    ctl.blk_end   = (d_addr_q == LastCol) || (ph_q == w_m1);
    ctl.cand      = (SW'(d_addr_q) + SW'(w_q)) < SW'(BLOCK_WIDTH);

    state_d  = state_q;
    w_d      = w_q;
    h_d      = h_q;
    addr_d   = addr_q;
    rcnt_d   = rcnt_q;
    ph_d     = ph_q;
    top_d    = top_q;
    d_vld_d  = 1'b0;
    d_fwd_d  = d_fwd_q;
    d_addr_d = addr_q;
    cur_d    = cur_q;
    open_d   = open_q;
    rp_d     = rp_q;
    rx_d     = rx_q;
    ry_d     = ry_q;
    rok_d    = rok_q;
    ropen_d  = ropen_q;
    sky_we   = 1'b0;
    sky_re   = 1'b0;
    sky_wd   = top_q;

    out_valid_d = out_valid_q && out_stall_i;
    page_d      = page_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    ok_d        = ok_q;
    opened_d    = opened_q;

    // Column phase within its block: count up on the forward sweep, hold at
    // the last column, then count down on the backward sweep.
    if (ctl.fwd) begin
      if (d_addr_q == LastCol) begin
        ph_d = ph_q;
      end else begin
        ph_d = (ph_q == w_m1) ? '0 : ph_q + ReqW'(1);
      end
    end else if (ctl.bwd) begin
      ph_d = (ph_q == '0) ? w_m1 : ph_q - ReqW'(1);
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          w_d     = req_width_i;
          h_d     = HW'(req_height_i);
          ph_d    = '0;
          addr_d  = '0;
          ctl.clr = 1'b1;
          if (req_bad) begin
            // drop: no page can take it, state unchanged
            rp_d    = '0;
            rx_d    = '0;
            ry_d    = '0;
            rok_d   = 1'b0;
            ropen_d = 1'b0;
            state_d = ST_RESP;
          end else if (!open_q) begin
            // first request opens page zero
            cur_d   = '0;
            open_d  = 1'b1;
            rp_d    = '0;
            rx_d    = '0;
            ry_d    = '0;
            rok_d   = 1'b1;
            ropen_d = 1'b1;
            state_d = ST_CLEAR;
          end else begin
            state_d = ST_FWD;
          end
        end
      end
      ST_FWD: begin
        sky_re   = 1'b1;
        d_vld_d  = 1'b1;
        d_fwd_d  = 1'b1;
        if (addr_q == LastCol) begin
          state_d = ST_BWD;
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end
      ST_BWD: begin
        sky_re   = 1'b1;
        d_vld_d  = 1'b1;
        d_fwd_d  = 1'b0;
        if (addr_q == '0) begin
          state_d = ST_EVAL;
        end else begin
          addr_d = addr_q - AW'(1);
        end
      end
      ST_EVAL: begin
        // wait for the last column to leave the data stage
        if (!d_vld_q) begin
          if (fits) begin
            rp_d    = PageW'(cur_q);
            rx_d    = PosW'(bx);
            ry_d    = PosW'(best);
            rok_d   = 1'b1;
            ropen_d = 1'b0;
            top_d   = best + h_q;
            addr_d  = bx;
            rcnt_d  = w_q;
            state_d = ST_RAISE;
          end else if (next_page < (PW + 1)'(MAX_PAGES)) begin
            cur_d   = PW'(next_page);
            open_d  = 1'b1;
            rp_d    = PageW'(next_page);
            rx_d    = '0;
            ry_d    = '0;
            rok_d   = 1'b1;
            ropen_d = 1'b1;
            addr_d  = '0;
            state_d = ST_CLEAR;
          end else begin
            rp_d    = '0;
            rx_d    = '0;
            ry_d    = '0;
            rok_d   = 1'b0;
            ropen_d = 1'b0;
            state_d = ST_RESP;
          end
        end
      end
      ST_RAISE: begin
        sky_we = 1'b1;
        sky_wd = top_q;
        addr_d = addr_q + AW'(1);
        rcnt_d = rcnt_q - ReqW'(1);
        if (rcnt_q == ReqW'(1)) begin
          state_d = ST_RESP;
        end
      end
      ST_CLEAR: begin
        // sweep the new page: first w columns at h, the rest at zero
        sky_we = 1'b1;
        sky_wd = (SW'(addr_q) < SW'(w_q)) ? h_q : '0;
        if (addr_q == LastCol) begin
          state_d = ST_RESP;
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end
      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          page_d      = rp_q;
          pos_x_d     = rx_q;
          pos_y_d     = ry_q;
          ok_d        = rok_q;
          opened_d    = ropen_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      d_vld_q     <= 1'b0;
      cur_q       <= '0;
      open_q      <= 1'b0;
      out_valid_q <= 1'b0;
      rcnt_q      <= '0;
      addr_q      <= '0;
    end else begin
      state_q     <= state_d;
      d_vld_q     <= d_vld_d;
      cur_q       <= cur_d;
      open_q      <= open_d;
      out_valid_q <= out_valid_d;
      rcnt_q      <= rcnt_d;
      addr_q      <= addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q      <= w_d;
    h_q      <= h_d;
    ph_q     <= ph_d;
    top_q    <= top_d;
    d_fwd_q  <= d_fwd_d;
    d_addr_q <= d_addr_d;
    rp_q     <= rp_d;
    rx_q     <= rx_d;
    ry_q     <= ry_d;
    rok_q    <= rok_d;
    ropen_q  <= ropen_d;
    page_q   <= page_d;
    pos_x_q  <= pos_x_d;
    pos_y_q  <= pos_y_d;
    ok_q     <= ok_d;
    opened_q <= opened_d;
  end

  // Skyline store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (sky_we) begin
      sky_mem[addr_q] <= sky_wd;
    end
    if (sky_re) begin
      sky_rd_q <= sky_mem[addr_q];
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign page_o        = page_q;
  assign pos_x_o       = pos_x_q;
  assign pos_y_o       = pos_y_q;
  assign ok_o          = ok_q;
  assign opened_page_o = opened_q;

`ifndef ASSERT_OFF
  ap_fail_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |->
      page_o == '0 && pos_x_o == '0 && pos_y_o == '0 && !opened_page_o)
    else $error("failed transaction carries nonzero fields");

  ap_open_at_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && opened_page_o |-> ok_o && pos_x_o == '0 && pos_y_o == '0)
    else $error("new page placement not at origin");

  ap_page_stays_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |=> open_q)
    else $error("open page flag dropped");

  ap_raise_in_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RAISE |-> (SW'(addr_q) + SW'(rcnt_q)) <= SW'(BLOCK_WIDTH))
    else $error("column raise runs past the page edge");
`endif

endmodule

`default_nettype wire

FILE: verif/tb_skyline_lightmap_allocator.sv
`default_nettype none

// Expected placement for one request.
typedef struct {
  logic [sla_pkg::PAGE_W-1:0] page;
  logic [sla_pkg::POS_W-1:0]  pos_x;
  logic [sla_pkg::POS_W-1:0]  pos_y;
  logic                       ok;
  logic                       opened_page;
} placement_t;

class atlas_scoreboard;
  localparam int COLS  = sla_pkg::BLOCK_WIDTH_DEF;
  localparam int ROWS  = sla_pkg::BLOCK_HEIGHT_DEF;
  localparam int PAGES = sla_pkg::MAX_PAGES_DEF;

  logic [7:0]  heights[COLS];
  int          open_page;
  bit          have_page;
  placement_t  placements[$];
  int          errors;

  function new();
    foreach (heights[i]) heights[i] = '0;
    open_page = 0;
    have_page = 1'b0;
    errors    = 0;
  endfunction

  // First start column whose window top is strictly lowest; the last
  // start column is never tried.
  function bit fit_on_page(int w, int h, output int x, output int y);
    int lowest;
    int top;
    bit found;
    lowest = ROWS;
    found  = 1'b0;
    x = 0;
    y = 0;
    if (w == 0 || w >= COLS) return 1'b0;
    for (int s = 0; s < COLS - w; s++) begin
      top = 0;
      for (int c = 0; c < w; c++)
        if (int'(heights[s+c]) > top) top = int'(heights[s+c]);
      if (top < lowest) begin
        lowest = top;
        x      = s;
        found  = 1'b1;
      end
    end
    if (!found || lowest + h > ROWS) return 1'b0;
    y = lowest;
    return 1'b1;
  endfunction

  function void raise_span(int x, int w, int top);
    for (int c = 0; c < w && x + c < COLS; c++) heights[x+c] = top[7:0];
  endfunction

  // Predict the placement of an accepted request and queue it.
  function void note_request(logic [7:0] req_w, logic [7:0] req_h);
    placement_t p;
    int w, h, x, y, next;
    w = int'(req_w);
    h = int'(req_h);
    p = '{page: '0, pos_x: '0, pos_y: '0, ok: 1'b0, opened_page: 1'b0};
    if (w != 0 && h != 0) begin
      if (have_page && fit_on_page(w, h, x, y)) begin
        raise_span(x, w, y + h);
        p.page  = open_page[7:0];
        p.pos_x = x[6:0];
        p.pos_y = y[6:0];
        p.ok    = 1'b1;
      end else begin
        next = have_page ? open_page + 1 : 0;
        if (next < PAGES && w < COLS && h <= ROWS) begin
          foreach (heights[i]) heights[i] = '0;
          raise_span(0, w, h);
          open_page        = next;
          have_page        = 1'b1;
          p.page           = next[7:0];
          p.ok             = 1'b1;
          p.opened_page    = 1'b1;
        end
      end
    end
    placements.insert(placements.size(), p);
  endfunction

  function void cmp_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  function void check_result(logic [7:0] page, logic [6:0] pos_x, logic [6:0] pos_y,
                             logic ok, logic opened_page);
    placement_t p;
    if (placements.size() == 0) begin
      $error("result with no request pending: page %0d x %0d y %0d ok %0b",
             page, pos_x, pos_y, ok);
      errors++;
      return;
    end
    p = placements.pop_front();
    cmp_field("page", int'(p.page), int'(page));
    cmp_field("pos_x", int'(p.pos_x), int'(pos_x));
    cmp_field("pos_y", int'(p.pos_y), int'(pos_y));
    cmp_field("ok", int'(p.ok), int'(ok));
    cmp_field("opened_page", int'(p.opened_page), int'(opened_page));
  endfunction

  function int pending();
    return placements.size();
  endfunction
endclass

module tb_skyline_lightmap_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS      = sla_pkg::BLOCK_WIDTH_DEF;
  localparam int ROWS      = sla_pkg::BLOCK_HEIGHT_DEF;
  localparam int PAGES     = sla_pkg::MAX_PAGES_DEF;
  localparam int RAND_REQS = 200;
  localparam int HOLD_AT   = 120;   // result count at which the receiver holds off
  localparam int HOLD_LEN  = 3000;  // length of that hold-off in cycles
  localparam int LIMIT     = 2_000_000;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic [sla_pkg::REQ_W-1:0]    req_width_i = '0;
  logic [sla_pkg::REQ_W-1:0]    req_height_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [sla_pkg::PAGE_W-1:0]   page_o;
  logic [sla_pkg::POS_W-1:0]    pos_x_o;
  logic [sla_pkg::POS_W-1:0]    pos_y_o;
  logic                         ok_o;
  logic                         opened_page_o;

  atlas_scoreboard sb = new();
  int              sent_count;
  int              result_count;
  int              cycle_count;

  skyline_lightmap_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_width_i   (req_width_i),
    .req_height_i  (req_height_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .page_o        (page_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .ok_o          (ok_o),
    .opened_page_o (opened_page_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: end the run if the block hangs.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count == LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Offer one request; return once the transaction has been accepted.
  // Idle gaps are drawn per request, except in runs of back-to-back traffic
  // so that valid stays high across consecutive transactions.
  task automatic send_request(logic [7:0] w, logic [7:0] h);
    int gap;
    gap = (sent_count % 50 < 12) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_width_i  <= w;
    req_height_i <= h;
    // Values read at the edge are the ones the block saw before it.
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(w, h);
    sent_count++;
  endtask

  // Receiver: draw a stall for every result, hold off once for a long
  // stretch so the block backs up into the request channel, and check
  // each accepted transaction against the oldest prediction.
  initial begin
    int wait_cycles;
    result_count = 0;
    @(posedge rst_ni);
    forever begin
      if (result_count == HOLD_AT)
        wait_cycles = HOLD_LEN;
      else if (result_count % 64 < 16)
        wait_cycles = 0;
      else
        wait_cycles = $urandom_range(0, 11);
      if (wait_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(page_o, pos_x_o, pos_y_o, ok_o, opened_page_o);
      result_count++;
    end
  end

  initial begin
    int legal;
    int pick;
    logic [7:0] w, h;
    sent_count = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: rejects before any page exists, the first page, size
    // extremes, too wide, too tall, and a full-height column.
    send_request(8'd0, 8'd5);
    send_request(8'd5, 8'd0);
    send_request(8'd128, 8'd4);
    send_request(8'd1, 8'd1);
    send_request(8'd0, 8'd0);
    send_request(8'd255, 8'd255);
    send_request(8'd4, 8'd129);
    send_request(8'd200, 8'd3);
    send_request(8'd3, 8'd200);
    send_request(8'd1, 8'd128);
    send_request(8'd1, 8'd127);
    send_request(8'd127, 8'd1);
    send_request(8'd127, 8'd128);
    send_request(8'd64, 8'd64);
    send_request(8'd63, 8'd64);
    send_request(8'd1, 8'd64);
    send_request(8'd1, 8'd1);
    send_request(8'd126, 8'd2);
    send_request(8'd128, 8'd128);
    send_request(8'd85, 8'd170);
    send_request(8'd42, 8'd21);

    // Random: mostly small rectangles so pages fill gradually and the
    // lowest-window search sees ragged skylines; some large ones force
    // page changes; the rest is noise over the full field range.
    legal = 0;
    while (legal < RAND_REQS) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        w = 8'($urandom_range(0, 255));
        h = 8'($urandom_range(0, 255));
      end else if (pick < 20) begin
        w = 8'($urandom_range(40, 127));
        h = 8'($urandom_range(20, 128));
      end else begin
        w = 8'($urandom_range(1, 32));
        h = 8'($urandom_range(1, 32));
      end
      if (w >= 1 && w < COLS && h >= 1 && h <= ROWS) legal++;
      send_request(w, h);
    end

    // Exhaust the pages: each widest-allowed, full-height rectangle opens a
    // new page, then everything must be refused.
    while (!(sb.have_page && sb.open_page == PAGES - 1))
      send_request(8'd127, 8'd128);
    send_request(8'd127, 8'd128);
    send_request(8'd1, 8'd1);
    send_request(8'd5, 8'd7);
    send_request(8'd127, 8'd1);

    // Drain, then leave room for a stray result.
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3 * COLS + 20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

`default_nettype wire
